@@ sv/ffea_pkg.sv @@
// Shared types and constants for the first-fit extent allocator.
// Used by ffea_cell and first_fit_extent_allocator_core.
`default_nettype none
package ffea_pkg;

  localparam int MAX_EXTENTS = 64;

  localparam logic [19:0] BYTE_LIMIT  = 20'hFFFF0;
  localparam logic [20:0] ROUND_ADD   = 21'd21;
  localparam logic [17:0] SPACE_END   = 18'h10000;
  localparam logic [16:0] LEN_MAX     = 17'h1FFFF;
  localparam logic [15:0] LIVE_MAX    = 16'hFFFF;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LARGE = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [19:0] request_bytes;
    logic [15:0] block_base;
    logic [16:0] block_paragraphs;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_base;
    logic [16:0] free_total;
    logic [15:0] live_blocks;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SHRINK,
    CMD_DROP,
    CMD_BOTH,
    CMD_PREV,
    CMD_NEXT,
    CMD_INSERT
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] nb;
    logic [16:0] amt;
    logic [16:0] need;
  } ctl_t;

  typedef struct packed {
    logic        v;
    logic [15:0] b;
    logic [16:0] l;
  } cell_t;

  typedef struct packed {
    logic fit;
    logic exact;
    logic stop;
    logic jn;
    logic ends;
  } flag_t;

endpackage
`default_nettype wire

@@ sv/first_fit_extent_allocator_core.sv @@
// First-fit extent allocator: a chain of MAX_EXTENTS cells in base order.
// A scan token walks one cell per cycle; an apply state then updates cells.
// Rejected or zero-length words skip the scan and go straight to done; others
// scan until the token stops and pass through apply only when cells change.
// One word in flight at a time. Reset (rst, sync) empties the table and
// clears both counters; no clearing pass is needed.
`default_nettype none
module first_fit_extent_allocator_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffea_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ffea_pkg::rsp_t rsp
);
  import ffea_pkg::*;

  localparam int N = MAX_EXTENTS;

  state_t state, state_next;
  ctl_t   ctl;
  cmd_t   cmd, cmd_next;
  logic        mode;
  logic [15:0] nb;
  logic [16:0] amt;
  logic [16:0] need;
  logic [N-1:0] tok, passed;
  logic         tok_end;
  logic [1:0]   res_status, res_status_next;
  logic [15:0]  res_granted, res_granted_next;
  logic [16:0]  free_total;
  logic [15:0]  live;
  logic         load_tok, adv_tok;

  cell_t cq [N];
  flag_t fl [N];
  logic [N-1:0] vvec;

  logic        sel_v, sel_fit, sel_exact, sel_stop, sel_jn, sel_jp;
  logic [15:0] sel_b;
  logic [20:0] need_sum;
  logic [17:0] end_sum;
  logic [17:0] free_add;

  assign ctl = '{cmd: cmd, nb: nb, amt: amt, need: need};

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      cell_t lft, rgt;
      logic  tr;
      if (gi == 0) begin : g_l0
        assign lft = '0;
      end else begin : g_ln
        assign lft = cq[gi-1];
      end
      if (gi == N-1) begin : g_rn
        assign rgt = '0;
        assign tr  = tok_end;
      end else begin : g_r
        assign rgt = cq[gi+1];
        assign tr  = tok[gi+1];
      end
      ffea_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .left (lft),
        .right(rgt),
        .tok  (tok[gi]),
        .tok_r(tr),
        .after(!passed[gi] && !tok[gi]),
        .q    (cq[gi]),
        .fl   (fl[gi])
      );
      assign vvec[gi] = cq[gi].v;
    end
  endgenerate

  always_comb begin
    sel_v = 1'b0; sel_fit = 1'b0; sel_exact = 1'b0;
    sel_stop = 1'b0; sel_jn = 1'b0; sel_jp = 1'b0;
    sel_b = '0;
    for (int i = 0; i < N; i++) begin
      sel_v     = sel_v     | (tok[i] & cq[i].v);
      sel_fit   = sel_fit   | (tok[i] & fl[i].fit);
      sel_exact = sel_exact | (tok[i] & fl[i].exact);
      sel_stop  = sel_stop  | (tok[i] & fl[i].stop);
      sel_jn    = sel_jn    | (tok[i] & fl[i].jn);
      sel_b     = sel_b     | ({16{tok[i]}} & cq[i].b);
    end
    for (int i = 1; i < N; i++) begin
      sel_jp = sel_jp | (tok[i] & fl[i-1].ends);
    end
  end

  assign need_sum = {1'b0, req.request_bytes} + ROUND_ADD;
  assign end_sum  = {2'b0, req.block_base} + {1'b0, req.block_paragraphs};
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    cmd_next         = CMD_NONE;
    res_status_next  = res_status;
    res_granted_next = res_granted;
    load_tok         = 1'b0;
    adv_tok          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          load_tok         = 1'b1;
          res_status_next  = ST_OK;
          res_granted_next = '0;
          if (!req.mode && req.request_bytes > BYTE_LIMIT) begin
            res_status_next = ST_LARGE;
            state_next      = S_DONE;
          end else if (req.mode && req.block_paragraphs == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok_end) begin
          if (!mode) begin
            res_status_next = ST_NOFIT;
            state_next      = S_DONE;
          end else if (fl[N-1].ends) begin
            cmd_next   = CMD_PREV;
            state_next = S_APPLY;
          end else begin
            res_status_next = ST_FULL;
            state_next      = S_DONE;
          end
        end else if (!mode) begin
          if (!sel_v) begin
            res_status_next = ST_NOFIT;
            state_next      = S_DONE;
          end else if (sel_fit) begin
            cmd_next         = sel_exact ? CMD_DROP : CMD_SHRINK;
            res_granted_next = sel_b;
            state_next       = S_APPLY;
          end else begin
            adv_tok = 1'b1;
          end
        end else begin
          if (sel_stop) begin
            state_next = S_APPLY;
            if (sel_jp && sel_jn)  cmd_next = CMD_BOTH;
            else if (sel_jp)       cmd_next = CMD_PREV;
            else if (sel_jn)       cmd_next = CMD_NEXT;
            else if (vvec[N-1]) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              cmd_next = CMD_INSERT;
            end
          end else begin
            adv_tok = 1'b1;
          end
        end
      end
      S_APPLY: state_next = S_DONE;
      S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= CMD_NONE;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= '0;
      passed  <= '0;
      tok_end <= 1'b0;
    end else if (load_tok) begin
      tok     <= {{(N-1){1'b0}}, 1'b1};
      passed  <= '0;
      tok_end <= 1'b0;
    end else if (adv_tok) begin
      tok     <= tok << 1;
      passed  <= passed | tok;
      tok_end <= tok[N-1];
    end
  end

  always_ff @(posedge clk) begin
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    if (state == S_IDLE && req_valid) begin
      mode <= req.mode;
      nb   <= req.block_base;
      need <= need_sum[20:4];
      amt  <= (end_sum > SPACE_END) ? 17'(SPACE_END - {2'b0, req.block_base})
                                    : req.block_paragraphs;
    end
  end

  assign free_add = {1'b0, free_total} + {1'b0, amt};

  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= '0;
      live       <= '0;
    end else if (state == S_APPLY) begin
      if (!mode) begin
        free_total <= (free_total >= need) ? free_total - need : '0;
        if (live != LIVE_MAX) live <= live + 16'd1;
      end else begin
        free_total <= free_add[17] ? LEN_MAX : free_add[16:0];
        if (live != '0) live <= live - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp <= '{status: res_status, granted_base: res_granted,
               free_total: free_total, live_blocks: live};
    end
  end

  a_tok_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> $onehot({tok, tok_end}))
    else $error("scan token not one-hot");

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    ((vvec >> 1) & ~vvec) == '0)
    else $error("extent chain has a hole");

  a_cmd_apply: assert property (@(posedge clk) disable iff (rst)
    state != S_APPLY |-> cmd == CMD_NONE)
    else $error("cell command outside apply");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_base == '0)
    else $error("grant with failing status");

endmodule
`default_nettype wire

@@ sv/ffea_cell.sv @@
// One extent slot of the sorted free-extent chain.
// Depends on ffea_pkg; trades data with its left and right neighbors.
`default_nettype none
module ffea_cell (
  input  logic           clk,
  input  logic           rst,
  input  ffea_pkg::ctl_t  ctl,
  input  ffea_pkg::cell_t left,
  input  ffea_pkg::cell_t right,
  input  logic           tok,
  input  logic           tok_r,
  input  logic           after,
  output ffea_pkg::cell_t q,
  output ffea_pkg::flag_t fl
);
  import ffea_pkg::*;

  logic        v, v_next;
  logic [15:0] b, b_next;
  logic [16:0] l, l_next;
  logic [17:0] both_sum;

  assign q = '{v: v, b: b, l: l};

  always_comb begin
    fl.fit   = v && (l >= ctl.need);
    fl.exact = (l == ctl.need);
    fl.stop  = !v || (b > ctl.nb);
    fl.jn    = v && (({2'b0, ctl.nb} + {1'b0, ctl.amt}) == {2'b0, b});
    fl.ends  = v && (({2'b0, b} + {1'b0, l}) == {2'b0, ctl.nb});
  end

  always_comb begin
    both_sum = {1'b0, l} + {1'b0, ctl.amt} + {1'b0, right.l};
    v_next = v;
    b_next = b;
    l_next = l;
    case (ctl.cmd)
      CMD_SHRINK: begin
        if (tok) begin
          b_next = b + ctl.need[15:0];
          l_next = l - ctl.need;
        end
      end
      CMD_DROP: begin
        if (tok || after) begin
          v_next = right.v;
          b_next = right.b;
          l_next = right.l;
        end
      end
      CMD_BOTH: begin
        if (tok_r) l_next = both_sum[16:0];
        if (tok || after) begin
          v_next = right.v;
          b_next = right.b;
          l_next = right.l;
        end
      end
      CMD_PREV: begin
        if (tok_r) l_next = l + ctl.amt;
      end
      CMD_NEXT: begin
        if (tok) begin
          b_next = ctl.nb;
          l_next = l + ctl.amt;
        end
      end
      CMD_INSERT: begin
        if (tok) begin
          v_next = 1'b1;
          b_next = ctl.nb;
          l_next = ctl.amt;
        end else if (after) begin
          v_next = left.v;
          b_next = left.b;
          l_next = left.l;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else     v <= v_next;
  end

  always_ff @(posedge clk) begin
    b <= b_next;
    l <= l_next;
  end

endmodule
`default_nettype wire
